// File: hw/rtl/sst_pkg.sv
package sst_pkg;

    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int SYMBOL_BITS_DEF  = 16;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int LEVEL_BITS_DEF   = 8;
    localparam int STATUS_BITS      = 3;
    localparam int OP_BITS          = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_ENTER  = 2'd0,
        OP_LEAVE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_UNDER    = 3'd4,
        ST_OVER     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic sym_eq;
        logic lvl_eq;
    } t_cmp;

endpackage

// File: hw/rtl/sst_cmp.sv
module sst_cmp #(
    parameter int SYMBOL_BITS = sst_pkg::SYMBOL_BITS_DEF,
    parameter int LEVEL_BITS  = sst_pkg::LEVEL_BITS_DEF
) (
    input  logic [SYMBOL_BITS-1:0] i_entry_sym,
    input  logic [LEVEL_BITS-1:0]  i_entry_lvl,
    input  logic [SYMBOL_BITS-1:0] i_key_sym,
    input  logic [LEVEL_BITS-1:0]  i_key_lvl,
    output sst_pkg::t_cmp          o_cmp
);
    import sst_pkg::*;

    always_comb begin
        o_cmp.sym_eq = (i_entry_sym == i_key_sym);
        o_cmp.lvl_eq = (i_entry_lvl == i_key_lvl);
    end

endmodule

// File: hw/rtl/sst_seq.sv
module sst_seq #(
    parameter int TABLE_DEPTH  = sst_pkg::TABLE_DEPTH_DEF,
    parameter int SYMBOL_BITS  = sst_pkg::SYMBOL_BITS_DEF,
    parameter int PAYLOAD_BITS = sst_pkg::PAYLOAD_BITS_DEF,
    parameter int LEVEL_BITS   = sst_pkg::LEVEL_BITS_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sst_pkg::OP_BITS-1:0]      i_op,
    input  logic [SYMBOL_BITS-1:0]           i_ident,
    input  logic [PAYLOAD_BITS-1:0]          i_type_payload,
    output logic                             o_res_valid,
    input  logic                             i_res_take,
    output sst_pkg::t_status                 o_status,
    output logic [PAYLOAD_BITS-1:0]          o_found_payload,
    output logic [LEVEL_BITS-1:0]            o_found_scope,
    output logic [LEVEL_BITS-1:0]            o_level_now,
    output logic                             o_mem_we,
    output logic [AW-1:0]                    o_mem_waddr,
    output logic [SYMBOL_BITS-1:0]           o_mem_wsym,
    output logic [LEVEL_BITS-1:0]            o_mem_wlvl,
    output logic [PAYLOAD_BITS-1:0]          o_mem_wpay,
    output logic [AW-1:0]                    o_mem_raddr,
    input  logic [SYMBOL_BITS-1:0]           i_mem_rsym,
    input  logic [LEVEL_BITS-1:0]            i_mem_rlvl,
    input  logic [PAYLOAD_BITS-1:0]          i_mem_rpay
);
    import sst_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [LEVEL_BITS-1:0] LVL_MAX = '1;
    localparam logic [CW-1:0] CNT_FULL = CW'(TABLE_DEPTH);

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [SYMBOL_BITS-1:0]  r_sym, n_sym;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;
    logic [CW-1:0]           r_count, n_count;
    logic [LEVEL_BITS-1:0]   r_level, n_level;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_pend, n_pend;
    logic [AW-1:0]           r_caddr, n_caddr;
    t_status                 r_status, n_status;
    logic [PAYLOAD_BITS-1:0] r_fpay, n_fpay;
    logic [LEVEL_BITS-1:0]   r_flev, n_flev;

    t_cmp                    w_cmp;
    logic                    w_stop;
    logic                    w_exh;
    logic [CW-1:0]           w_idx_m1;
    logic                    w_imm;

    sst_cmp #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_cmp (
        .i_entry_sym (i_mem_rsym),
        .i_entry_lvl (i_mem_rlvl),
        .i_key_sym   (r_sym),
        .i_key_lvl   (r_level),
        .o_cmp       (w_cmp)
    );

    assign w_idx_m1 = r_idx - CW'(1);
    assign w_imm    = (t_op'(i_op) == OP_ENTER) ||
                      ((t_op'(i_op) == OP_LEAVE) && (r_level == '0));

    // scan decisions on the entry read last cycle
    always_comb begin
        w_stop = 1'b0;
        if (r_pend) begin
            unique case (r_op)
                OP_LEAVE:  w_stop = !w_cmp.lvl_eq;
                OP_INSERT: w_stop = !w_cmp.lvl_eq || w_cmp.sym_eq;
                OP_LOOKUP: w_stop = w_cmp.sym_eq;
                default:   w_stop = 1'b1;
            endcase
        end
        w_exh = !r_pend && (r_idx == '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_imm ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_stop || w_exh) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op        = r_op;
        n_sym       = r_sym;
        n_pay       = r_pay;
        n_count     = r_count;
        n_level     = r_level;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_caddr     = r_caddr;
        n_status    = r_status;
        n_fpay      = r_fpay;
        n_flev      = r_flev;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_count[AW-1:0];
        o_mem_wsym  = r_sym;
        o_mem_wlvl  = r_level;
        o_mem_wpay  = r_pay;
        o_mem_raddr = w_idx_m1[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = t_op'(i_op);
                    n_sym    = i_ident;
                    n_pay    = i_type_payload;
                    n_idx    = r_count;
                    n_pend   = 1'b0;
                    n_status = ST_OK;
                    n_fpay   = '0;
                    n_flev   = '0;
                    if (t_op'(i_op) == OP_ENTER) begin
                        if (r_level == LVL_MAX) begin
                            n_status = ST_OVER;
                        end else begin
                            n_level = r_level + LEVEL_BITS'(1);
                        end
                    end else if ((t_op'(i_op) == OP_LEAVE) && (r_level == '0)) begin
                        n_status = ST_UNDER;
                    end
                end
            end
            S_SCAN: begin
                if (w_stop) begin
                    n_pend = 1'b0;
                    unique case (r_op)
                        OP_LEAVE: begin
                            n_count = CW'(r_caddr) + CW'(1);
                            n_level = r_level - LEVEL_BITS'(1);
                        end
                        OP_INSERT: begin
                            if (w_cmp.lvl_eq) begin
                                n_status = ST_DUP;
                            end else if (r_count == CNT_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_we = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_LOOKUP: begin
                            n_fpay = i_mem_rpay;
                            n_flev = i_mem_rlvl;
                        end
                        default: n_status = ST_OK;
                    endcase
                end else if (w_exh) begin
                    unique case (r_op)
                        OP_LEAVE: begin
                            n_count = '0;
                            n_level = r_level - LEVEL_BITS'(1);
                        end
                        OP_INSERT: begin
                            if (r_count == CNT_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_we = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_LOOKUP: n_status = ST_NOTFOUND;
                        default:   n_status = ST_OK;
                    endcase
                end else if (r_idx != '0) begin
                    n_idx   = w_idx_m1;
                    n_pend  = 1'b1;
                    n_caddr = w_idx_m1[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_DONE: begin
                n_pend = 1'b0;
            end
            default: n_pend = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_level <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_level <= n_level;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_sym    <= n_sym;
        r_pay    <= n_pay;
        r_idx    <= n_idx;
        r_caddr  <= n_caddr;
        r_status <= n_status;
        r_fpay   <= n_fpay;
        r_flev   <= n_flev;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_res_valid     = (r_state == S_DONE);
    assign o_status        = r_status;
    assign o_found_payload = r_fpay;
    assign o_found_scope   = r_flev;
    assign o_level_now     = r_level;

endmodule

// File: hw/rtl/sst_mem.sv
module sst_mem #(
    parameter int TABLE_DEPTH  = sst_pkg::TABLE_DEPTH_DEF,
    parameter int SYMBOL_BITS  = sst_pkg::SYMBOL_BITS_DEF,
    parameter int PAYLOAD_BITS = sst_pkg::PAYLOAD_BITS_DEF,
    parameter int LEVEL_BITS   = sst_pkg::LEVEL_BITS_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [SYMBOL_BITS-1:0]  i_wsym,
    input  logic [LEVEL_BITS-1:0]   i_wlvl,
    input  logic [PAYLOAD_BITS-1:0] i_wpay,
    input  logic [AW-1:0]           i_raddr,
    output logic [SYMBOL_BITS-1:0]  o_rsym,
    output logic [LEVEL_BITS-1:0]   o_rlvl,
    output logic [PAYLOAD_BITS-1:0] o_rpay
);

    localparam int EW = SYMBOL_BITS + LEVEL_BITS + PAYLOAD_BITS;

    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic [EW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wsym, i_wlvl, i_wpay};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign {o_rsym, o_rlvl, o_rpay} = r_rdata;

endmodule

// File: hw/rtl/scoped_symbol_table.sv
// channel   direction  handshake                    payload
// request   in         i_in_valid / o_in_stall      i_op, i_ident, i_type_payload
// response  out        o_out_valid / i_out_stall    o_status, o_found_payload,
//                                                   o_found_scope, o_level_now
//
// Enter scope and failing leave skip the scan and go from transfer straight to the result register.
// Leave, insert and lookup scan the table newest first, one entry per cycle
// through the entry RAM read port. One request at a time; o_in_stall is high
// from transfer until the result is loaded into the output register, which
// holds while i_out_stall is high.
// Synchronous reset empties the table and returns to scope zero.
module scoped_symbol_table #(
    parameter int TABLE_DEPTH  = sst_pkg::TABLE_DEPTH_DEF,
    parameter int SYMBOL_BITS  = sst_pkg::SYMBOL_BITS_DEF,
    parameter int PAYLOAD_BITS = sst_pkg::PAYLOAD_BITS_DEF,
    parameter int LEVEL_BITS   = sst_pkg::LEVEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sst_pkg::OP_BITS-1:0]         i_op,
    input  logic [SYMBOL_BITS-1:0]              i_ident,
    input  logic [PAYLOAD_BITS-1:0]             i_type_payload,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sst_pkg::STATUS_BITS-1:0]     o_status,
    output logic [PAYLOAD_BITS-1:0]             o_found_payload,
    output logic [LEVEL_BITS-1:0]               o_found_scope,
    output logic [LEVEL_BITS-1:0]               o_level_now
);
    import sst_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                    w_mem_we;
    logic [AW-1:0]           w_mem_waddr;
    logic [SYMBOL_BITS-1:0]  w_mem_wsym;
    logic [LEVEL_BITS-1:0]   w_mem_wlvl;
    logic [PAYLOAD_BITS-1:0] w_mem_wpay;
    logic [AW-1:0]           w_mem_raddr;
    logic [SYMBOL_BITS-1:0]  w_mem_rsym;
    logic [LEVEL_BITS-1:0]   w_mem_rlvl;
    logic [PAYLOAD_BITS-1:0] w_mem_rpay;

    logic                    w_res_valid;
    logic                    w_load;
    t_status                 w_status;
    logic [PAYLOAD_BITS-1:0] w_fpay;
    logic [LEVEL_BITS-1:0]   w_flev;
    logic [LEVEL_BITS-1:0]   w_level;

    logic                    r_ovalid;
    t_status                 r_ostatus;
    logic [PAYLOAD_BITS-1:0] r_ofpay;
    logic [LEVEL_BITS-1:0]   r_oflev;
    logic [LEVEL_BITS-1:0]   r_olevel;

    sst_seq #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SYMBOL_BITS  (SYMBOL_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .LEVEL_BITS   (LEVEL_BITS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_ident         (i_ident),
        .i_type_payload  (i_type_payload),
        .o_res_valid     (w_res_valid),
        .i_res_take      (w_load),
        .o_status        (w_status),
        .o_found_payload (w_fpay),
        .o_found_scope   (w_flev),
        .o_level_now     (w_level),
        .o_mem_we        (w_mem_we),
        .o_mem_waddr     (w_mem_waddr),
        .o_mem_wsym      (w_mem_wsym),
        .o_mem_wlvl      (w_mem_wlvl),
        .o_mem_wpay      (w_mem_wpay),
        .o_mem_raddr     (w_mem_raddr),
        .i_mem_rsym      (w_mem_rsym),
        .i_mem_rlvl      (w_mem_rlvl),
        .i_mem_rpay      (w_mem_rpay)
    );

    sst_mem #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SYMBOL_BITS  (SYMBOL_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .LEVEL_BITS   (LEVEL_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wsym  (w_mem_wsym),
        .i_wlvl  (w_mem_wlvl),
        .i_wpay  (w_mem_wpay),
        .i_raddr (w_mem_raddr),
        .o_rsym  (w_mem_rsym),
        .o_rlvl  (w_mem_rlvl),
        .o_rpay  (w_mem_rpay)
    );

    // output register frees when empty or being transferred
    assign w_load = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && w_res_valid) begin
            r_ostatus <= w_status;
            r_ofpay   <= w_fpay;
            r_oflev   <= w_flev;
            r_olevel  <= w_level;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_found_payload = r_ofpay;
    assign o_found_scope   = r_oflev;
    assign o_level_now     = r_olevel;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request side not busy after transfer");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ostatus != ST_OK)) |-> ((r_ofpay == '0) && (r_oflev == '0)))
        else $error("found fields nonzero on failed request");

    a_under_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ostatus == ST_UNDER)) |-> (r_olevel == '0))
        else $error("scope underflow reported above scope zero");

    a_over_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ostatus == ST_OVER)) |-> (r_olevel == {LEVEL_BITS{1'b1}}))
        else $error("scope overflow reported below top scope");

endmodule

// File: sim/tb_top.sv
module tb_top;
    import sst_pkg::*;

    localparam int TBL_DEPTH     = TABLE_DEPTH_DEF;
    localparam int SYM_W         = SYMBOL_BITS_DEF;
    localparam int PAY_W         = PAYLOAD_BITS_DEF;
    localparam int LVL_W         = LEVEL_BITS_DEF;
    localparam int LVL_TOP       = (1 << LVL_W) - 1;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int PRESSURE_AT   = 200;
    localparam int PRESSURE_HOLD = 600;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int DIR_ROWS      = 23;

    typedef struct packed {
        t_status          status;
        logic [PAY_W-1:0] payload;
        logic [LVL_W-1:0] scope;
        logic [LVL_W-1:0] level;
    } t_sym_reply;

    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] ident;
        logic [PAY_W-1:0] payload;
        logic             typed;
        t_status          status;
        logic [PAY_W-1:0] found_payload;
        logic [LVL_W-1:0] found_scope;
        logic [LVL_W-1:0] level;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [OP_BITS-1:0]     i_op;
    logic [SYM_W-1:0]       i_ident;
    logic [PAY_W-1:0]       i_type_payload;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [STATUS_BITS-1:0] o_status;
    logic [PAY_W-1:0]       o_found_payload;
    logic [LVL_W-1:0]       o_found_scope;
    logic [LVL_W-1:0]       o_level_now;

    // shadow of the symbol stack
    logic [SYM_W-1:0] sym_stack_ident   [TBL_DEPTH];
    logic [LVL_W-1:0] sym_stack_scope   [TBL_DEPTH];
    logic [PAY_W-1:0] sym_stack_payload [TBL_DEPTH];
    int               sym_depth;
    logic [LVL_W-1:0] scope_level;

    t_sym_reply pending_replies[$];
    int         requests_sent;
    int         replies_seen;
    int         mismatches;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{OP_LEAVE,  16'h0000, 32'h0000_0000, 1'b1, ST_UNDER,    32'h0000_0000, 8'd0, 8'd0},
        '{OP_LOOKUP, 16'h0000, 32'h0000_0000, 1'b1, ST_NOTFOUND, 32'h0000_0000, 8'd0, 8'd0},
        '{OP_INSERT, 16'h0000, 32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000, 8'd0, 8'd0},
        '{OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,       32'h0000_0000, 8'd0, 8'd0},
        '{OP_INSERT, 16'h0000, 32'h0000_0001, 1'b1, ST_DUP,      32'h0000_0000, 8'd0, 8'd0},
        '{OP_LOOKUP, 16'hFFFF, 32'h0000_0000, 1'b1, ST_OK,       32'hFFFF_FFFF, 8'd0, 8'd0},
        '{OP_ENTER,  16'h0000, 32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000, 8'd0, 8'd1},
        '{OP_INSERT, 16'h0000, 32'hA5A5_5A5A, 1'b0, ST_OK,       32'h0000_0000, 8'd0, 8'd0},
        '{OP_LOOKUP, 16'h0000, 32'h0000_0000, 1'b1, ST_OK,       32'hA5A5_5A5A, 8'd1, 8'd1},
        '{OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,       32'hFFFF_FFFF, 8'd0, 8'd1},
        '{OP_ENTER,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,       32'h0000_0000, 8'd0, 8'd2},
        '{OP_INSERT, 16'h1234, 32'h8000_0000, 1'b0, ST_OK,       32'h0000_0000, 8'd0, 8'd0},
        '{OP_INSERT, 16'hFFFF, 32'h0000_0001, 1'b0, ST_OK,       32'h0000_0000, 8'd0, 8'd0},
        '{OP_LOOKUP, 16'hFFFF, 32'h0000_0000, 1'b1, ST_OK,       32'h0000_0001, 8'd2, 8'd2},
        '{OP_LEAVE,  16'h0000, 32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000, 8'd0, 8'd1},
        '{OP_LOOKUP, 16'h1234, 32'h0000_0000, 1'b1, ST_NOTFOUND, 32'h0000_0000, 8'd0, 8'd1},
        '{OP_LOOKUP, 16'hFFFF, 32'h0000_0000, 1'b1, ST_OK,       32'hFFFF_FFFF, 8'd0, 8'd1},
        '{OP_LEAVE,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,       32'h0000_0000, 8'd0, 8'd0},
        '{OP_LOOKUP, 16'h0000, 32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000, 8'd0, 8'd0},
        '{OP_LEAVE,  16'h0000, 32'h0000_0000, 1'b1, ST_UNDER,    32'h0000_0000, 8'd0, 8'd0},
        '{OP_LOOKUP, 16'h5555, 32'h0000_0000, 1'b1, ST_NOTFOUND, 32'h0000_0000, 8'd0, 8'd0},
        '{OP_INSERT, 16'hAAAA, 32'h5555_5555, 1'b0, ST_OK,       32'h0000_0000, 8'd0, 8'd0},
        '{OP_LOOKUP, 16'hAAAA, 32'h0000_0000, 1'b1, ST_OK,       32'h5555_5555, 8'd0, 8'd0}
    };

    scoped_symbol_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_ident         (i_ident),
        .i_type_payload  (i_type_payload),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_found_payload (o_found_payload),
        .o_found_scope   (o_found_scope),
        .o_level_now     (o_level_now)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_sym_reply resolve_request(input t_op op, input logic [SYM_W-1:0] id,
                                                   input logic [PAY_W-1:0] pay);
        t_sym_reply r;
        int         i;
        r.status  = ST_OK;
        r.payload = '0;
        r.scope   = '0;
        case (op)
            OP_ENTER: begin
                if (scope_level == LVL_TOP) r.status = ST_OVER;
                else scope_level = scope_level + 1'b1;
            end
            OP_LEAVE: begin
                if (scope_level == 0) begin
                    r.status = ST_UNDER;
                end else begin
                    while (sym_depth > 0 && sym_stack_scope[sym_depth-1] == scope_level)
                        sym_depth--;
                    scope_level = scope_level - 1'b1;
                end
            end
            OP_INSERT: begin
                for (i = sym_depth - 1; i >= 0; i--) begin
                    if (sym_stack_scope[i] != scope_level) break;
                    if (sym_stack_ident[i] == id) begin
                        r.status = ST_DUP;
                        break;
                    end
                end
                if (r.status == ST_OK) begin
                    if (sym_depth >= TBL_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        sym_stack_ident[sym_depth]   = id;
                        sym_stack_scope[sym_depth]   = scope_level;
                        sym_stack_payload[sym_depth] = pay;
                        sym_depth++;
                    end
                end
            end
            default: begin
                r.status = ST_NOTFOUND;
                for (i = sym_depth - 1; i >= 0; i--) begin
                    if (sym_stack_ident[i] == id) begin
                        r.status  = ST_OK;
                        r.payload = sym_stack_payload[i];
                        r.scope   = sym_stack_scope[i];
                        break;
                    end
                end
            end
        endcase
        r.level = scope_level;
        return r;
    endfunction

    task automatic offer_request(input t_op op, input logic [SYM_W-1:0] id,
                                 input logic [PAY_W-1:0] pay, input bit use_typed,
                                 input t_sym_reply typed_reply);
        int         gap;
        t_sym_reply predicted;
        gap = ((requests_sent / 64) % 4 == 1) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_ident        <= id;
        i_type_payload <= pay;
        do @(posedge i_clk); while (o_in_stall);
        predicted = resolve_request(op, id, pay);
        pending_replies.push_back(use_typed ? typed_reply : predicted);
        requests_sent++;
        @(negedge i_clk);
    endtask

    function automatic void check_reply();
        t_sym_reply want;
        if (pending_replies.size() == 0) begin
            $error("unexpected transfer: status %0d level %0d", o_status, o_level_now);
            mismatches++;
            return;
        end
        want = pending_replies.pop_front();
        if (o_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, o_status);
            mismatches++;
        end
        if (o_found_payload !== want.payload) begin
            $error("found_payload: expected %h, actual %h", want.payload, o_found_payload);
            mismatches++;
        end
        if (o_found_scope !== want.scope) begin
            $error("found_scope: expected %0d, actual %0d", want.scope, o_found_scope);
            mismatches++;
        end
        if (o_level_now !== want.level) begin
            $error("level_now: expected %0d, actual %0d", want.level, o_level_now);
            mismatches++;
        end
    endfunction

    initial begin : request_side
        int               n;
        int               pick;
        int               recent_wr;
        t_op              op;
        logic [SYM_W-1:0] id;
        logic [PAY_W-1:0] pay;
        logic [SYM_W-1:0] recent_ids [16];
        t_sym_reply       typed_reply;
        bit               filling;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = OP_ENTER;
        i_ident        = '0;
        i_type_payload = '0;
        sym_depth      = 0;
        scope_level    = '0;
        requests_sent  = 0;
        replies_seen   = 0;
        mismatches     = 0;
        recent_wr      = 0;
        for (n = 0; n < 16; n++) recent_ids[n] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++) begin
            typed_reply = '{dir_rows[n].status, dir_rows[n].found_payload,
                            dir_rows[n].found_scope, dir_rows[n].level};
            offer_request(dir_rows[n].op, dir_rows[n].ident, dir_rows[n].payload,
                          dir_rows[n].typed, typed_reply);
        end

        // phases: mixed, fill the table, mixed, climb to the top level, unwind, mixed
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick    = $urandom_range(0, 99);
            filling = (n >= 300 && n < 620);
            if (filling) begin
                if (pick < 94) op = OP_INSERT;
                else if (pick < 97) op = OP_ENTER;
                else op = OP_LOOKUP;
            end else if (n >= 800 && n < 1100) begin
                if (pick < 95) op = OP_ENTER;
                else op = OP_LOOKUP;
            end else if (n >= 1100 && n < 1380) begin
                if (pick < 90) op = OP_LEAVE;
                else op = OP_LOOKUP;
            end else begin
                if (pick < 15) op = OP_ENTER;
                else if (pick < 27) op = OP_LEAVE;
                else if (pick < 70) op = OP_INSERT;
                else op = OP_LOOKUP;
            end

            pick = $urandom_range(0, 9);
            if (filling && op == OP_INSERT) id = SYM_W'($urandom_range(0, 65535));
            else if (pick < 4) id = SYM_W'($urandom_range(0, 31));
            else if (pick < 7) id = recent_ids[4'($urandom_range(0, 15))];
            else id = SYM_W'($urandom_range(0, 65535));
            pay = $urandom;

            if (op == OP_INSERT) begin
                recent_ids[recent_wr] = id;
                recent_wr = (recent_wr + 1) % 16;
            end
            offer_request(op, id, pay, 1'b0, typed_reply);
        end
        i_in_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : reply_side
        int hold;
        bit on_valid;
        i_out_stall = 1'b0;
        hold        = 0;
        on_valid    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                check_reply();
                replies_seen++;
                if (replies_seen == PRESSURE_AT) begin
                    hold     = PRESSURE_HOLD;
                    on_valid = 1'b0;
                end else begin
                    hold     = ((replies_seen / 50) % 4 == 2) ? 0 : $urandom_range(0, 4);
                    on_valid = 1'($urandom_range(0, 1));
                end
            end else if (hold > 0 && (!on_valid || o_out_valid)) begin
                hold--;
            end
            @(negedge i_clk);
            i_out_stall <= (hold > 0);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/sst_pkg.sv
hw/rtl/sst_cmp.sv
hw/rtl/sst_seq.sv
hw/rtl/sst_mem.sv
hw/rtl/scoped_symbol_table.sv
sim/tb_top.sv
